>>> design/playfair_digram_substitution_core_defines.svh
// assertion macros shared by the playfair substitution design
`ifndef PLAYFAIR_DIGRAM_SUBSTITUTION_CORE_DEFINES_SVH
`define PLAYFAIR_DIGRAM_SUBSTITUTION_CORE_DEFINES_SVH

// same-cycle implication, held off while in reset
`define PDSUB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pdsub: same-cycle check failed");

// next-cycle implication, held off while in reset
`define PDSUB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pdsub: next-cycle check failed");

`endif

>>> design/pdsub_pkg.sv
// types and constants of the playfair digram substitution design
package pdsub_pkg;

	localparam int unsigned SIDE       = 5;
	localparam int unsigned CODE_W     = 5;
	localparam int unsigned POS_W      = 3;
	localparam int unsigned LOW_W      = 50;
	localparam int unsigned MID_W      = 50;
	localparam int unsigned HIGH_W     = 25;
	localparam int unsigned CFG_DATA_W = 50;
	localparam int unsigned CFG_IDX_W  = 2;

	localparam logic [CODE_W-1:0] CODE_I = 5'd8;
	localparam logic [CODE_W-1:0] CODE_J = 5'd9;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_MID  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_HIGH = 2'd2;

	localparam logic REQ_ENCRYPT = 1'b0;
	localparam logic REQ_DECRYPT = 1'b1;

	// key square: [row][column][code bit], cell (r,c) at bit (5r+c)*5
	typedef logic [SIDE-1:0][SIDE-1:0][CODE_W-1:0] square_t;

	typedef struct packed {
		logic              req_type;
		logic [CODE_W-1:0] first_letter;
		logic [CODE_W-1:0] second_letter;
	} in_beat_t;

	typedef struct packed {
		logic [CODE_W-1:0] first_result;
		logic [CODE_W-1:0] second_result;
		logic              letter_absent;
	} out_beat_t;

	// position of a letter in the square
	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} loc_t;

endpackage

>>> design/playfair_digram_substitution_core.sv
// top level of the playfair digram substitution core
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------
//  in       | in_valid / in_ready   | in_data  (req_type, two letter codes)
//  out      | out_valid / out_ready | out_data (two results, letter_absent)
//  cfg      | cfg_we                | cfg_index, cfg_data (key square)
//
// one digram beat accepted per cycle while out is not stalled; each beat passes through the input
// register and then the result register before it appears on out, with lookup and
// substitution in one combinational pass between them
// arst_n clears the valid flags and the key square registers (all cells code 0)
// a stalled out beat holds in the result register while the input register still fills,
// after which in_ready drops until out_ready frees the result register
`include "playfair_digram_substitution_core_defines.svh"

module playfair_digram_substitution_core (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                in_valid,
	output logic                                in_ready,
	input  pdsub_pkg::in_beat_t                 in_data,

	output logic                                out_valid,
	input  logic                                out_ready,
	output pdsub_pkg::out_beat_t                out_data,

	input  logic                                cfg_we,
	input  logic [pdsub_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pdsub_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// key square registers
	logic [pdsub_pkg::LOW_W-1:0]  cells_low_q;
	logic [pdsub_pkg::MID_W-1:0]  cells_mid_q;
	logic [pdsub_pkg::HIGH_W-1:0] cells_high_q;
	pdsub_pkg::square_t           square;

	// stage 1: registered input beat
	logic                         valid_s1;
	pdsub_pkg::in_beat_t          beat_s1;

	// stage 2: registered result beat
	logic                         valid_s2;
	pdsub_pkg::out_beat_t         beat_s2;

	pdsub_pkg::loc_t              loc_a, loc_b;
	pdsub_pkg::out_beat_t         result;

	logic                         adv_s2;
	logic                         adv_s1;

	// configuration writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_low_q  <= '0;
			cells_mid_q  <= '0;
			cells_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pdsub_pkg::REG_CELLS_LOW:  cells_low_q  <= cfg_data[pdsub_pkg::LOW_W-1:0];
				pdsub_pkg::REG_CELLS_MID:  cells_mid_q  <= cfg_data[pdsub_pkg::MID_W-1:0];
				pdsub_pkg::REG_CELLS_HIGH: cells_high_q <= cfg_data[pdsub_pkg::HIGH_W-1:0];
				default: ;
			endcase
		end
	end

	// cell k sits at bits 5k+4..5k, so the concatenation maps straight onto rows and columns
	assign square = pdsub_pkg::square_t'({cells_high_q, cells_mid_q, cells_low_q});

	// handshake: each stage moves on when the one after it is empty or draining
	assign adv_s2   = !valid_s2 || out_ready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			beat_s1 <= in_data;
		end
	end

	// lookup of both letters runs in parallel
	pdsub_locate u_locate_a (
		.square (square),
		.letter (beat_s1.first_letter),
		.loc    (loc_a)
	);

	pdsub_locate u_locate_b (
		.square (square),
		.letter (beat_s1.second_letter),
		.loc    (loc_b)
	);

	pdsub_subst u_subst (
		.square   (square),
		.req_type (beat_s1.req_type),
		.loc_a    (loc_a),
		.loc_b    (loc_b),
		.result   (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			beat_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = beat_s2;

	// an absent letter always comes with zeroed result codes
	`PDSUB_ASSERT_NOW(a_absent_zero, clk, arst_n,
		valid_s2 && beat_s2.letter_absent,
		beat_s2.first_result == '0 && beat_s2.second_result == '0)
	// an accepted beat lands in the input register
	`PDSUB_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_valid && in_ready, valid_s1)
	// both stages full and out stalled means no room for a new beat
	`PDSUB_ASSERT_NOW(a_full_blocks_in, clk, arst_n,
		valid_s1 && valid_s2 && !out_ready, !in_ready)
	// a stalled result is never dropped from the result register
	`PDSUB_ASSERT_NEXT(a_stall_keeps_s2, clk, arst_n, valid_s2 && !out_ready, valid_s2)

endmodule

>>> design/pdsub_locate.sv
// finds the lowest square cell that holds a letter, j looked up as i
module pdsub_locate (
	input  pdsub_pkg::square_t                square,
	input  logic [pdsub_pkg::CODE_W-1:0]      letter,
	output pdsub_pkg::loc_t                   loc
);

	logic [pdsub_pkg::CODE_W-1:0] key;

	assign key = (letter == pdsub_pkg::CODE_J) ? pdsub_pkg::CODE_I : letter;

	// scan from the last cell down so the lowest match wins
	always_comb begin
		loc = '0;
		for (int r = pdsub_pkg::SIDE - 1; r >= 0; r--) begin
			for (int c = pdsub_pkg::SIDE - 1; c >= 0; c--) begin
				if (square[r][c] == key) begin
					loc.found = 1'b1;
					loc.row   = pdsub_pkg::POS_W'(r);
					loc.col   = pdsub_pkg::POS_W'(c);
				end
			end
		end
	end

endmodule

>>> design/pdsub_subst.sv
// applies the row, column and rectangle rules and reads the new letters
module pdsub_subst (
	input  pdsub_pkg::square_t    square,
	input  logic                  req_type,
	input  pdsub_pkg::loc_t       loc_a,
	input  pdsub_pkg::loc_t       loc_b,
	output pdsub_pkg::out_beat_t  result
);

	localparam logic [pdsub_pkg::POS_W-1:0] LAST  = pdsub_pkg::POS_W'(pdsub_pkg::SIDE - 1);
	localparam logic [pdsub_pkg::POS_W-1:0] FIRST = '0;
	localparam logic [pdsub_pkg::POS_W-1:0] ONE   = pdsub_pkg::POS_W'(1);

	// one step round the five positions, forward or back
	function automatic logic [pdsub_pkg::POS_W-1:0] wrap_step(
		input logic [pdsub_pkg::POS_W-1:0] p,
		input logic                        back
	);
		logic [pdsub_pkg::POS_W-1:0] n;
		if (back == pdsub_pkg::REQ_DECRYPT) begin
			n = (p == FIRST) ? LAST : p - ONE;
		end else begin
			n = (p == LAST) ? FIRST : p + ONE;
		end
		return n;
	endfunction

	logic [pdsub_pkg::POS_W-1:0] row_a, col_a, row_b, col_b;

	always_comb begin
		if (loc_a.row == loc_b.row) begin
			row_a = loc_a.row;
			row_b = loc_b.row;
			col_a = wrap_step(loc_a.col, req_type);
			col_b = wrap_step(loc_b.col, req_type);
		end else if (loc_a.col == loc_b.col) begin
			row_a = wrap_step(loc_a.row, req_type);
			row_b = wrap_step(loc_b.row, req_type);
			col_a = loc_a.col;
			col_b = loc_b.col;
		end else begin
			row_a = loc_a.row;
			row_b = loc_b.row;
			col_a = loc_b.col;
			col_b = loc_a.col;
		end
	end

	always_comb begin
		if (loc_a.found && loc_b.found) begin
			result.first_result  = square[row_a][col_a];
			result.second_result = square[row_b][col_b];
			result.letter_absent = 1'b0;
		end else begin
			result.first_result  = '0;
			result.second_result = '0;
			result.letter_absent = 1'b1;
		end
	end

endmodule
